/* rtl/permutation_unrank_defines.svh */
// assertion macros used by the checker file
`ifndef PERMUTATION_UNRANK_DEFINES_SVH
`define PERMUTATION_UNRANK_DEFINES_SVH

// same-cycle implication
`define PU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pu assertion failed");

// next-cycle implication
`define PU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pu assertion failed");

`endif

/* rtl/pu_pkg.sv */
`default_nettype none

package pu_pkg;

	localparam int MAX_ELEMENTS = 10;
	localparam int CNT_W        = 4;
	localparam int RANK_W       = 22;
	localparam int DIGIT_W      = 4;
	localparam int QUO_W        = $clog2(MAX_ELEMENTS);
	localparam int K_W          = $clog2(QUO_W);

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MAX_ELEMENTS);

	localparam logic [RANK_W-1:0] FACT_TABLE [MAX_ELEMENTS+1] = '{
		22'd1, 22'd1, 22'd2, 22'd6, 22'd24, 22'd120, 22'd720, 22'd5040,
		22'd40320, 22'd362880, 22'd3628800
	};

	typedef struct packed {
		logic               load;
		logic               advance;
		logic [DIGIT_W-1:0] sel;
	} cell_ctrl_t;

	typedef struct packed {
		logic           load;
		logic           step;
		logic [K_W-1:0] k;
	} div_ctrl_t;

	function automatic logic [RANK_W-1:0] fact(input logic [CNT_W-1:0] n);
		logic [RANK_W-1:0] f;
		f = '0;
		if (n <= CNT_W'(MAX_ELEMENTS)) begin
			f = FACT_TABLE[n];
		end
		return f;
	endfunction

endpackage

`default_nettype wire

/* rtl/pu_if.sv */
`default_nettype none

interface pu_in_if;
	import pu_pkg::*;

	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] rank;

	modport source (output valid, output rank, input ready);
	modport sink (input valid, input rank, output ready);
endinterface

interface pu_out_if;
	import pu_pkg::*;

	logic               valid;
	logic               ready;
	logic [DIGIT_W-1:0] digit;
	logic               last;
	logic               error;

	modport source (output valid, output digit, output last, output error, input ready);
	modport sink (input valid, input digit, input last, input error, output ready);
endinterface

`default_nettype wire

/* rtl/pu_cell.sv */
`default_nettype none

module pu_cell (
	input  wire logic                       clk,
	input  wire pu_pkg::cell_ctrl_t         ctrl,
	input  wire logic [pu_pkg::DIGIT_W-1:0] idx,
	input  wire logic [pu_pkg::DIGIT_W-1:0] nbr_digit,
	output logic      [pu_pkg::DIGIT_W-1:0] digit
);
	import pu_pkg::*;

	logic [DIGIT_W-1:0] digit_q;

	// on load each cell takes its own index; a removed slot closes up: every cell at or right of it takes its neighbor
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			digit_q <= idx;
		end else if (ctrl.advance && (idx >= ctrl.sel)) begin
			digit_q <= nbr_digit;
		end
	end

	assign digit = digit_q;

endmodule

`default_nettype wire

/* rtl/pu_div.sv */
`default_nettype none

module pu_div (
	input  wire logic                      clk,
	input  wire pu_pkg::div_ctrl_t         ctrl,
	input  wire logic [pu_pkg::RANK_W-1:0] load_rem,
	input  wire logic [pu_pkg::RANK_W-1:0] divisor,
	output logic      [pu_pkg::QUO_W-1:0]  quo
);
	import pu_pkg::*;

	localparam int WIDE_W = RANK_W + QUO_W;

	logic [RANK_W-1:0] rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [WIDE_W-1:0] trial;
	logic [WIDE_W-1:0] diff;
	logic              ge;
	logic [RANK_W-1:0] rem_next;
	logic [QUO_W-1:0]  quo_base;

	// restoring division, one quotient bit per step, msb first
	always_comb begin
		trial    = WIDE_W'(divisor) << ctrl.k;
		ge       = WIDE_W'(rem_q) >= trial;
		diff     = WIDE_W'(rem_q) - trial;
		rem_next = ge ? diff[RANK_W-1:0] : rem_q;
		quo_base = (ctrl.k == K_W'(QUO_W - 1)) ? '0 : quo_q;
		quo      = quo_base | (ge ? (QUO_W'(1) << ctrl.k) : '0);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q <= load_rem;
		end else if (ctrl.step) begin
			rem_q <= rem_next;
			quo_q <= quo;
		end
	end

endmodule

`default_nettype wire

/* rtl/permutation_unrank.sv */
// channel  dir  payload                 transfer
// req      in   rank[21:0]              valid && ready
// rsp      out  digit[3:0] last error   valid && ready
// cfg      in   cfg_wdata[3:0]          cfg_we
//
// one rank at a time; req.ready is high only while no rank is in work
// each digit comes from the radix-2 divider, one quotient bit per step, so a count of n gives n results;
// a rejected rank goes to S_ERR and gives its single result once the output slot is free
// a stall on rsp holds the divider on its final quotient bit until the slot frees
// arst_n clears control and output valid; the digit cells and divider need no reset
`default_nettype none

module permutation_unrank (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [pu_pkg::CNT_W-1:0]  cfg_wdata,
	pu_in_if.sink                          req,
	pu_out_if.source                       rsp
);
	import pu_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_ERR} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   pos_q;
	logic [K_W-1:0]     k_q;
	logic               out_valid_q;
	logic [DIGIT_W-1:0] digit_q;
	logic               last_q;
	logic               error_q;

	logic               accept;
	logic               bad;
	logic               slot_free;
	logic               emit_dig;
	logic               emit_err;
	logic [QUO_W-1:0]   quo;
	logic [RANK_W-1:0]  divisor;
	div_ctrl_t          div_ctrl;
	cell_ctrl_t         cell_ctrl;
	logic [DIGIT_W-1:0] cell_digit [MAX_ELEMENTS];

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign bad       = (cnt_q == '0) || (cnt_q > CNT_W'(MAX_ELEMENTS)) ||
	                   (req.rank == '0) || (req.rank > fact(cnt_q));
	assign slot_free = !out_valid_q || rsp.ready;
	assign emit_dig  = (state_q == S_RUN) && (k_q == '0) && slot_free;
	assign emit_err  = (state_q == S_ERR) && slot_free;
	assign divisor   = fact(pos_q - CNT_W'(1));

	always_comb begin
		div_ctrl.load  = accept && !bad;
		div_ctrl.step  = (state_q == S_RUN) && ((k_q != '0) || slot_free);
		div_ctrl.k     = k_q;
		cell_ctrl.load    = accept;
		cell_ctrl.advance = emit_dig;
		cell_ctrl.sel     = DIGIT_W'(quo);
	end

	pu_div u_div (
		.clk      (clk),
		.ctrl     (div_ctrl),
		.load_rem (req.rank - RANK_W'(1)),
		.divisor  (divisor),
		.quo      (quo)
	);

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		logic [DIGIT_W-1:0] nbr;
		if (i == MAX_ELEMENTS - 1) begin : g_end
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_digit[i+1];
		end
		pu_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl),
			.idx       (DIGIT_W'(i)),
			.nbr_digit (nbr),
			.digit     (cell_digit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_RESET;
		end else if (cfg_we) begin
			cnt_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			digit_q     <= '0;
			last_q      <= 1'b0;
			error_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pos_q   <= cnt_q;
						k_q     <= K_W'(QUO_W - 1);
						state_q <= bad ? S_ERR : S_RUN;
					end
				end
				S_RUN: begin
					if (k_q != '0) begin
						k_q <= k_q - K_W'(1);
					end else if (slot_free) begin
						pos_q <= pos_q - CNT_W'(1);
						k_q   <= K_W'(QUO_W - 1);
						if (pos_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ERR: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (emit_dig) begin
				out_valid_q <= 1'b1;
				digit_q     <= cell_digit[quo];
				last_q      <= (pos_q == CNT_W'(1));
				error_q     <= 1'b0;
			end else if (emit_err) begin
				out_valid_q <= 1'b1;
				digit_q     <= '0;
				last_q      <= 1'b1;
				error_q     <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.digit = digit_q;
	assign rsp.last  = last_q;
	assign rsp.error = error_q;

endmodule

`default_nettype wire

/* rtl/pu_checker.sv */
`default_nettype none
`include "permutation_unrank_defines.svh"

module pu_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_ready,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic [pu_pkg::DIGIT_W-1:0] rsp_digit,
	input wire logic                       rsp_last,
	input wire logic                       rsp_error
);
	import pu_pkg::*;

	`PU_ASSERT_IMP(a_err_last, rsp_valid && rsp_error, rsp_last && (rsp_digit == '0))
	`PU_ASSERT_IMP(a_digit_range, rsp_valid && !rsp_error, rsp_digit < DIGIT_W'(MAX_ELEMENTS))
	`PU_ASSERT_NXT(a_one_rank, req_valid && req_ready, !req_ready)
	`PU_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digit) && $stable(rsp_last) && $stable(rsp_error))

endmodule

bind permutation_unrank pu_checker u_pu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_digit (rsp.digit),
	.rsp_last  (rsp.last),
	.rsp_error (rsp.error)
);

`default_nettype wire
